FILE: hw/rtl/mlsd_pkg.sv
package mlsd_pkg;

   // Depth of the sliding hunt window: five marker bytes plus the length high byte.
   localparam int unsigned WinDepth = 6;
   localparam int unsigned MarkLen  = 5;
   localparam int unsigned FillW    = $clog2(WinDepth + 1);

   typedef logic [7:0] byte_type;

   // The frame start marker, ASCII "start".
   localparam byte_type MarkBytes [MarkLen] = '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74};

   typedef struct packed {
      byte_type    data_byte;
      logic        frame_end;
      logic        checksum_ok;
      logic [15:0] frame_length;
   } result_type;

endpackage

FILE: hw/rtl/mlsd_channels.sv
interface mlsd_req_if
   import mlsd_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlsd_rsp_if
   import mlsd_pkg::*;
();
   logic        valid;
   logic        ready;
   byte_type    data_byte;
   logic        frame_end;
   logic        checksum_ok;
   logic [15:0] frame_length;

   modport source (output valid, output data_byte, output frame_end, output checksum_ok,
                   output frame_length, input ready);
   modport sink   (input valid, input data_byte, input frame_end, input checksum_ok,
                   input frame_length, output ready);
endinterface

FILE: hw/rtl/mlsd_core.sv
module mlsd_core
   import mlsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  byte_type   rx_byte,
   output logic       has_result,
   output result_type result
);

   byte_type    win_ff [WinDepth];
   byte_type    win_in [WinDepth];
   logic [FillW-1:0] fill_ff, fill_in;
   logic        receiving_ff, receiving_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] seen_ff, seen_in;
   byte_type    sum_ff, sum_in;
   logic        mark_hit;
   logic        in_payload;

   always_comb begin
      mark_hit = 1'b1;
      for (int i = 0; i < MarkLen; i++) begin
         if (win_ff[i] != MarkBytes[i]) begin
            mark_hit = 1'b0;
         end
      end
   end

   assign in_payload = seen_ff < length_ff;
   assign has_result = receiving_ff;

   always_comb begin
      result.data_byte    = rx_byte;
      result.frame_length = length_ff;
      result.frame_end    = !in_payload;
      result.checksum_ok  = !in_payload && (sum_ff == rx_byte);
   end

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      receiving_in = receiving_ff;
      length_in    = length_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      if (step) begin
         if (!receiving_ff) begin
            if (fill_ff < FillW'(WinDepth)) begin
               win_in[fill_ff[FillW-1:0]] = rx_byte;
               fill_in = fill_ff + FillW'(1);
            end else if (mark_hit) begin
               length_in    = {win_ff[WinDepth-1], rx_byte};
               receiving_in = 1'b1;
               seen_in      = '0;
               sum_in       = '0;
               fill_in      = '0;
            end else begin
               for (int i = 0; i < WinDepth - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[WinDepth-1] = rx_byte;
            end
         end else if (in_payload) begin
            sum_in  = sum_ff + rx_byte;
            seen_in = seen_ff + 16'd1;
         end else begin
            receiving_in = 1'b0;
            fill_in      = '0;
            seen_in      = '0;
            sum_in       = '0;
         end
      end
   end

   // The window contents are only read once every entry has been written.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff      <= '0;
         receiving_ff <= 1'b0;
         length_ff    <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         fill_ff      <= fill_in;
         receiving_ff <= receiving_in;
         length_ff    <= length_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
      end
   end

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> seen_ff <= length_ff)
      else $error("payload count ran past the frame length");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(WinDepth))
      else $error("hunt window fill exceeds its depth");

   a_end_rehunts: assert property (@(posedge clock) disable iff (reset)
      step && receiving_ff && !in_payload |=> !receiving_ff && fill_ff == '0)
      else $error("frame end did not return to hunting with an empty window");

   a_header_locks: assert property (@(posedge clock) disable iff (reset)
      step && !receiving_ff && fill_ff == FillW'(WinDepth) && mark_hit
      |=> receiving_ff && seen_ff == '0 && sum_ff == '0)
      else $error("complete header did not start a frame");

endmodule

FILE: hw/rtl/marker_length_sum_deframer.sv
// Channel  | Direction | Handshake     | Payload
// req_ch   | in        | valid/ready   | rx_byte
// rsp_ch   | out       | valid/ready   | data_byte, frame_end, checksum_ok, frame_length
//
// One byte per cycle is accepted and handled, unless a full result slot holds a byte that
// makes a result. An accepted byte is loaded into the input register; when it advances, it
// moves through the core into the result register, from which its result is offered.
// The state update in the core sets that rate.
// Reset is synchronous and active high; it clears all control state and starts hunting.
// A stalled result register holds only bytes that produce results: hunting bytes
// keep flowing while a result waits.
module marker_length_sum_deframer
   import mlsd_pkg::*;
(
   input logic          clock,
   input logic          reset,
   mlsd_req_if.sink     req_ch,
   mlsd_rsp_if.source   rsp_ch
);

   // Input register: one received byte waiting to be processed.
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       core_has_result;
   result_type core_result;
   logic       out_free;
   logic       advance;
   logic       req_fire;

   mlsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .has_result (core_has_result),
      .result     (core_result)
   );

   // The result slot is free if empty or being drained this cycle.
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // A byte moves on when it makes no result, or when the result slot can take it.
   assign advance = in_valid_ff && (!core_has_result || out_free);

   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && core_has_result) begin
         out_valid_in = 1'b1;
         out_in       = core_result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.data_byte    = out_ff.data_byte;
   assign rsp_ch.frame_end    = out_ff.frame_end;
   assign rsp_ch.checksum_ok  = out_ff.checksum_ok;
   assign rsp_ch.frame_length = out_ff.frame_length;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !(advance && core_has_result))
      else $error("pending result overwritten");

   a_ok_only_at_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !out_ff.checksum_ok || out_ff.frame_end)
      else $error("checksum flag on a payload byte");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("waiting input byte lost");

endmodule

FILE: dv/tb_top.sv
module tb_top;
   import mlsd_pkg::*;

   // Longest wait that either side draws for one transaction.
   localparam int unsigned MaxIdle     = 10;
   // Length of the one long receiver hold-off in the backpressure test.
   localparam int unsigned HoldCycles  = 400;
   // Bytes inside frames that the random traffic test sends before it stops.
   localparam int unsigned RandomItems = 900;
   // Cycles allowed for the last results to drain once the sender is done.
   localparam int unsigned DrainLimit  = 20000;
   // Cycles allowed after the last result, in case the block emits something extra.
   localparam int unsigned TailCycles  = 16;
   // Hard stop for the whole run, in time units.
   localparam int unsigned RunLimit    = 8_000_000;
   // Payload length of a long frame whose length needs both header bytes.
   localparam int unsigned LongLen     = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlsd_req_if req_ch ();
   mlsd_rsp_if rsp_ch ();

   marker_length_sum_deframer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock with a period of four time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Deframer predictor state. It mirrors the block: a six-byte hunt window
   // that slides while no marker is found, then a payload counter and a
   // modulo-256 running sum while a frame is open.
   // ------------------------------------------------------------------------
   byte_type    hunt_win [WinDepth];
   int unsigned win_count     = 0;
   bit          in_frame      = 1'b0;
   logic [15:0] frame_len     = '0;
   logic [15:0] payload_count = '0;
   byte_type    sum_acc       = '0;

   // Results the deframer owes us, oldest first.
   result_type  expected_results [$];

   // Payload of the next frame that send_frame puts on the wire.
   byte_type    payload_q [$];

   // Idling controls for both sides, and the request for a long receiver hold-off.
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          hold_go      = 1'b0;
   logic        rsp_hold     = 1'b0;

   // Bookkeeping for the run summary and the verdict.
   int unsigned error_count    = 0;
   int unsigned results_passed = 0;
   int unsigned frames_closed  = 0;
   int unsigned sums_matched   = 0;
   int unsigned payload_bytes  = 0;
   int unsigned bytes_sent     = 0;

   // Only the first ten problems are printed in full; the rest are counted.
   function automatic void note_error(input string msg);
      if (error_count < 10) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      error_count++;
   endfunction

   // Advances the predictor by one accepted byte and queues the result it causes.
   function automatic void track_byte(input byte_type value);
      result_type outcome;
      bit         marker_hit;
      bytes_sent++;
      if (!in_frame) begin
         // While hunting no result is ever produced, not even on the byte
         // that completes the header.
         if (win_count < WinDepth) begin
            hunt_win[win_count] = value;
            win_count++;
            return;
         end
         marker_hit = 1'b1;
         for (int i = 0; i < MarkLen; i++) begin
            if (hunt_win[i] != MarkBytes[i]) begin
               marker_hit = 1'b0;
            end
         end
         if (marker_hit) begin
            // The length is big-endian: its high byte is the window's last entry.
            frame_len     = {hunt_win[WinDepth-1], value};
            in_frame      = 1'b1;
            payload_count = '0;
            sum_acc       = '0;
            win_count     = 0;
         end else begin
            // No marker yet, so the oldest byte drops out of the window.
            for (int i = 0; i < WinDepth - 1; i++) begin
               hunt_win[i] = hunt_win[i+1];
            end
            hunt_win[WinDepth-1] = value;
         end
         return;
      end

      outcome.data_byte    = value;
      outcome.frame_length = frame_len;
      if (payload_count < frame_len) begin
         sum_acc             += value;
         payload_count++;
         outcome.frame_end   = 1'b0;
         outcome.checksum_ok = 1'b0;
         payload_bytes++;
      end else begin
         // The byte after the payload is the checksum; it closes the frame
         // whether or not it matches, and hunting restarts from an empty window.
         outcome.frame_end   = 1'b1;
         outcome.checksum_ok = (sum_acc == value);
         in_frame            = 1'b0;
         win_count           = 0;
         payload_count       = '0;
         sum_acc             = '0;
         frames_closed++;
         if (outcome.checksum_ok) begin
            sums_matched++;
         end
      end
      expected_results.push_back(outcome);
   endfunction

   // Offers one byte after a random gap and waits until the block accepts it.
   // Valid stays high after the transaction; the next call either lowers it
   // for a gap or replaces the byte, so valid never gets two updates in one step.
   task automatic send_byte(input byte_type value);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      track_byte(value);
   endtask

   function automatic void fill_payload(input int unsigned len);
      payload_q.delete();
      repeat (len) payload_q.push_back(byte_type'($urandom_range(0, 255)));
   endfunction

   task automatic send_marker();
      for (int i = 0; i < MarkLen; i++) begin
         send_byte(MarkBytes[i]);
      end
   endtask

   // Sends marker, length, payload_q and a checksum; a corrupt frame gets a
   // checksum that differs from the true sum in at least one bit.
   task automatic send_frame(input bit corrupt);
      int unsigned len;
      byte_type    sum;
      len = payload_q.size();
      sum = '0;
      send_marker();
      send_byte(byte_type'(len >> 8));
      send_byte(byte_type'(len));
      foreach (payload_q[i]) begin
         send_byte(payload_q[i]);
         sum += payload_q[i];
      end
      send_byte(corrupt ? (sum ^ byte_type'($urandom_range(1, 255))) : sum);
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count) send_byte(byte_type'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Result side: the receiver draws a stall before each transaction and
   // honors the long hold-off while it is active.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      forever begin
         stall = recv_idle_on ? $urandom_range(0, MaxIdle) : 0;
         if (stall > 0 || rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // The long hold-off is timed here, apart from the sender, so that the
   // sender keeps offering bytes while the receiver refuses results.
   initial begin : hold_timer
      forever begin
         wait (hold_go);
         hold_go = 1'b0;
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (HoldCycles) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Every result transaction is compared with the oldest expected result.
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{data_byte:    rsp_ch.data_byte,
                 frame_end:    rsp_ch.frame_end,
                 checksum_ok:  rsp_ch.checksum_ok,
                 frame_length: rsp_ch.frame_length};
         if (expected_results.size() == 0) begin
            note_error($sformatf("unexpected result: data %02h end %b ok %b len %0d",
                                 got.data_byte, got.frame_end, got.checksum_ok,
                                 got.frame_length));
         end else begin
            want = expected_results.pop_front();
            if (got.data_byte !== want.data_byte || got.frame_end !== want.frame_end ||
                got.checksum_ok !== want.checksum_ok ||
                got.frame_length !== want.frame_length) begin
               note_error($sformatf({"result mismatch: expected data %02h end %b ok %b ",
                                     "len %0d, got data %02h end %b ok %b len %0d"},
                                    want.data_byte, want.frame_end, want.checksum_ok,
                                    want.frame_length, got.data_byte, got.frame_end,
                                    got.checksum_ok, got.frame_length));
            end else begin
               results_passed++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // An empty frame: the byte right after the header is the checksum itself,
   // good only when it is zero.
   task automatic test_zero_length();
      payload_q.delete();
      send_frame(1'b0);
      send_frame(1'b1);
   endtask

   // Payload and checksum bytes at both ends of the byte range, a sum that
   // wraps around, and a wrong checksum that must still close the frame.
   task automatic test_checksum();
      payload_q = '{8'hFF, 8'hFF};
      send_frame(1'b0);
      payload_q = '{8'hFF, 8'h01};
      send_frame(1'b0);
      payload_q = '{8'h00, 8'h80};
      send_frame(1'b1);
   endtask

   // Partial and misspelled markers in front of a real one: the window has to
   // slide byte by byte and still lock onto the marker that follows.
   task automatic test_marker_slide();
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int i = 0; i < 3; i++) begin
         send_byte(MarkBytes[i]);
      end
      for (int i = 0; i < MarkLen; i++) begin
         send_byte(i == 2 ? (MarkBytes[i] ^ 8'h01) : MarkBytes[i]);
      end
      payload_q = '{8'h5A};
      send_frame(1'b0);
   endtask

   // Frames with no gap between them: the next header follows the checksum
   // immediately, on both sides without idling.
   task automatic test_back_to_back();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      for (int i = 0; i < 3; i++) begin
         fill_payload(i + 1);
         send_frame(1'b0);
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // A long frame whose length uses the high header byte, with idling off
   // to keep it quick.
   task automatic test_long_frame();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      fill_payload(LongLen);
      send_frame(1'b0);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while payload and hunting
   // bytes keep coming, so the block fills up and has to stall its input.
   task automatic test_backpressure();
      send_idle_on = 1'b0;
      hold_go      = 1'b1;
      fill_payload(120);
      send_frame(1'b0);
      send_noise(12);
      fill_payload(40);
      send_frame(1'b1);
      send_idle_on = 1'b1;
   endtask

   // Mostly well-formed frames with random content and length, mixed with
   // bad checksums, line noise and broken markers. Idling is switched per
   // item so that some stretches run at full rate.
   task automatic test_random_traffic();
      int unsigned framed;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      framed = 0;
      while (framed < RandomItems) begin
         pick         = $urandom_range(0, 19);
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (pick < 15) begin
            // Most frames are short; now and then a longer one.
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300)
                                                : $urandom_range(0, 16);
            fill_payload(len);
            send_frame(pick >= 12);
            framed += len + 8;
         end else if (pick < 18) begin
            send_noise($urandom_range(1, 8));
         end else begin
            // A marker that is cut short or has one byte wrong. A complete
            // marker is never sent here, since it would open a frame.
            cut = $urandom_range(0, MarkLen - 1);
            if (pick == 18) begin
               for (int i = 0; i < cut + 1 && i < MarkLen - 1; i++) begin
                  send_byte(MarkBytes[i]);
               end
            end else begin
               for (int i = 0; i < MarkLen; i++) begin
                  send_byte(i == cut ? (MarkBytes[i] ^ byte_type'($urandom_range(1, 255)))
                                     : MarkBytes[i]);
               end
            end
         end
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence: reset once, run every test in turn, drain, then report.
   // ------------------------------------------------------------------------
   initial begin : sequencer
      int unsigned waited;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_zero_length();
      test_checksum();
      test_marker_slide();
      test_back_to_back();
      test_long_frame();
      test_backpressure();
      test_random_traffic();

      // The last transaction was accepted at this edge, so valid can drop now.
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (TailCycles) @(posedge clock);
      if (expected_results.size() != 0) begin
         note_error($sformatf("%0d expected results never arrived",
                              expected_results.size()));
      end

      $display("Sent %0d bytes; %0d frames closed (%0d with a matching checksum).",
               bytes_sent, frames_closed, sums_matched);
      $display("%0d payload bytes passed on, %0d results matched, %0d errors.",
               payload_bytes, results_passed, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Safety net in case the block deadlocks or never returns a result.
   initial begin : watchdog
      #(RunLimit);
      $display("Run limit reached with %0d results outstanding.", expected_results.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
